/* hdl/ictr_pkg.sv */
// ----------------------------------------------------------------------------
// Input change trace recorder package
// Shared sizes, register codes, controller states and the axis clamp.
// ----------------------------------------------------------------------------
package ictr_pkg;

   localparam int EVENT_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(EVENT_DEPTH);
   localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);

   localparam int TICK_W      = 32;
   localparam int AXIS_W      = 16;
   localparam int AXES_W      = 4 * AXIS_W;
   localparam int BTN_W       = 12;
   localparam int PTR_W       = 2 * AXIS_W + BTN_W;
   localparam int ENTRY_W     = TICK_W + AXES_W + PTR_W;
   localparam int STORED_W    = 13;

   // mode register codes; the spare code acts as idle
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_RECORD = 2'd1;
   localparam logic [1:0] MODE_PLAY   = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   localparam logic [AXIS_W-1:0] AXIS_MOST_NEG = 16'h8000;
   localparam logic [AXIS_W-1:0] AXIS_FLOOR    = 16'h8001;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Q1.15 axis: the most negative code is pulled up to the symmetric floor
   function automatic logic [AXIS_W-1:0] clamp_axis(input logic [AXIS_W-1:0] raw);
      return (raw == AXIS_MOST_NEG) ? AXIS_FLOOR : raw;
   endfunction

endpackage

/* hdl/ictr_req_if.sv */
// ----------------------------------------------------------------------------
// Snapshot request channel
// Valid/ready channel carrying one tick's controller snapshot.
// ----------------------------------------------------------------------------
interface ictr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] tick;
   logic signed [15:0] move_x;
   logic signed [15:0] move_y;
   logic signed [15:0] aim_x;
   logic signed [15:0] aim_y;
   logic signed [15:0] pointer_x;
   logic signed [15:0] pointer_y;
   logic [11:0] buttons;

   modport source (
      output valid, tick, move_x, move_y, aim_x, aim_y, pointer_x, pointer_y, buttons,
      input  ready
   );
   modport sink (
      input  valid, tick, move_x, move_y, aim_x, aim_y, pointer_x, pointer_y, buttons,
      output ready
   );
endinterface

/* hdl/ictr_rsp_if.sv */
// ----------------------------------------------------------------------------
// Applied snapshot response channel
// Valid/ready channel carrying the applied snapshot and store status.
// ----------------------------------------------------------------------------
interface ictr_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] applied_move_x;
   logic signed [15:0] applied_move_y;
   logic signed [15:0] applied_aim_x;
   logic signed [15:0] applied_aim_y;
   logic signed [15:0] applied_pointer_x;
   logic signed [15:0] applied_pointer_y;
   logic [11:0] applied_buttons;
   logic        event_stored;
   logic        store_full;
   logic [12:0] stored_events;

   modport source (
      output valid, applied_move_x, applied_move_y, applied_aim_x, applied_aim_y,
             applied_pointer_x, applied_pointer_y, applied_buttons,
             event_stored, store_full, stored_events,
      input  ready
   );
   modport sink (
      input  valid, applied_move_x, applied_move_y, applied_aim_x, applied_aim_y,
             applied_pointer_x, applied_pointer_y, applied_buttons,
             event_stored, store_full, stored_events,
      output ready
   );
endinterface

/* hdl/input_change_trace_recorder_unit.sv */
// ----------------------------------------------------------------------------
// Input change trace recorder
// Records changed controller snapshots into an event RAM and replays them.
// ----------------------------------------------------------------------------
// Flow: a snapshot is captured in idle, then passes the finish state, or in
//   playback the scan state first, which consumes due events one per cycle.
// Throughput: one item in flight; a full output register holds the item in
//   the finish state, and no new snapshot is taken until it commits.
// Reset: control state, counters and snapshots clear at once; the event RAM
//   is not cleared, only entries below the event count are ever read.
// ----------------------------------------------------------------------------
module input_change_trace_recorder_unit (
   input  logic       clock,
   input  logic       reset,
   ictr_req_if.sink   req_ch,
   ictr_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   // ------------------------------------------------------------------------
   // State and registers
   // ------------------------------------------------------------------------
   ictr_pkg::state_type state_ff, state_in;

   logic [1:0]                    mode_ff, mode_in;
   logic [ictr_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ictr_pkg::CNT_W-1:0]    play_index_ff, play_index_in;
   logic                          have_last_ff, have_last_in;
   logic [ictr_pkg::AXES_W-1:0]   last_axes_ff, last_axes_in;
   logic [ictr_pkg::PTR_W-1:0]    last_ptr_ff, last_ptr_in;
   logic [ictr_pkg::AXES_W-1:0]   held_axes_ff, held_axes_in;
   logic [ictr_pkg::PTR_W-1:0]    held_ptr_ff, held_ptr_in;

   // captured item
   logic [ictr_pkg::TICK_W-1:0]   item_tick_ff, item_tick_in;
   logic [ictr_pkg::AXES_W-1:0]   item_axes_ff, item_axes_in;
   logic [ictr_pkg::PTR_W-1:0]    item_ptr_ff, item_ptr_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ictr_pkg::AXES_W-1:0]   rsp_axes_ff, rsp_axes_in;
   logic [ictr_pkg::PTR_W-1:0]    rsp_ptr_ff, rsp_ptr_in;
   logic                          rsp_stored_ff, rsp_stored_in;
   logic                          rsp_full_ff, rsp_full_in;
   logic [ictr_pkg::STORED_W-1:0] rsp_count_ff, rsp_count_in;

   // RAM port
   logic                          wr_en;
   logic [ictr_pkg::ENTRY_W-1:0]  wr_data;
   logic [ictr_pkg::ENTRY_W-1:0]  rd_data;
   logic [ictr_pkg::TICK_W-1:0]   rd_tick;
   logic [ictr_pkg::AXES_W-1:0]   rd_axes;
   logic [ictr_pkg::PTR_W-1:0]    rd_ptr;

   logic req_fire;
   logic out_free;
   logic changed;
   logic room;
   logic consume;

   // ------------------------------------------------------------------------
   // Event RAM: entry is {tick, pointer/buttons, axes}. The read address is
   // the next play index, so the data seen in a cycle belongs to the current
   // play index.
   // ------------------------------------------------------------------------
   ictr_ram #(
      .WIDTH (ictr_pkg::ENTRY_W),
      .DEPTH (ictr_pkg::EVENT_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ictr_pkg::ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (play_index_in[ictr_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_axes = rd_data[ictr_pkg::AXES_W-1:0];
   assign rd_ptr  = rd_data[ictr_pkg::AXES_W +: ictr_pkg::PTR_W];
   assign rd_tick = rd_data[ictr_pkg::AXES_W + ictr_pkg::PTR_W +: ictr_pkg::TICK_W];
   assign wr_data = {item_tick_ff, item_ptr_ff, item_axes_ff};

   assign req_ch.ready = (state_ff == ictr_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // record decision: first snapshot of the run, or any field differs
   assign changed = !have_last_ff || (item_axes_ff != last_axes_ff) ||
                    (item_ptr_ff != last_ptr_ff);
   assign room    = (count_ff < ictr_pkg::CNT_W'(ictr_pkg::EVENT_DEPTH));

   // playback: consume the event under the play index if it is due
   assign consume = (play_index_ff < count_ff) && (rd_tick <= item_tick_ff);

   // ------------------------------------------------------------------------
   // Control state machine and next-value logic
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      play_index_in = play_index_ff;
      have_last_in  = have_last_ff;
      last_axes_in  = last_axes_ff;
      last_ptr_in   = last_ptr_ff;
      held_axes_in  = held_axes_ff;
      held_ptr_in   = held_ptr_ff;
      item_tick_in  = item_tick_ff;
      item_axes_in  = item_axes_ff;
      item_ptr_in   = item_ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_axes_in   = rsp_axes_ff;
      rsp_ptr_in    = rsp_ptr_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;

      case (state_ff)
         ictr_pkg::ST_IDLE: begin
            if (req_fire) begin
               // capture the snapshot with the axes clamped
               item_tick_in = req_ch.tick;
               item_axes_in = {ictr_pkg::clamp_axis(req_ch.aim_y),
                               ictr_pkg::clamp_axis(req_ch.aim_x),
                               ictr_pkg::clamp_axis(req_ch.move_y),
                               ictr_pkg::clamp_axis(req_ch.move_x)};
               item_ptr_in  = {req_ch.buttons, req_ch.pointer_y, req_ch.pointer_x};
               state_in     = (mode_ff == ictr_pkg::MODE_PLAY) ? ictr_pkg::ST_SCAN
                                                               : ictr_pkg::ST_FINISH;
            end
         end

         ictr_pkg::ST_SCAN: begin
            // advance over every due event, one per cycle
            if (consume) begin
               held_axes_in  = rd_axes;
               held_ptr_in   = rd_ptr;
               play_index_in = play_index_ff + 1'b1;
            end else begin
               state_in = ictr_pkg::ST_FINISH;
            end
         end

         ictr_pkg::ST_FINISH: begin
            // hold until the output register is free, then commit
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_stored_in = 1'b0;
               rsp_full_in   = 1'b0;
               rsp_axes_in   = item_axes_ff;
               rsp_ptr_in    = item_ptr_ff;
               if (mode_ff == ictr_pkg::MODE_PLAY) begin
                  rsp_axes_in = held_axes_ff;
                  rsp_ptr_in  = held_ptr_ff;
               end
               if (mode_ff == ictr_pkg::MODE_RECORD && changed) begin
                  if (room) begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + 1'b1;
                     rsp_stored_in = 1'b1;
                  end else begin
                     rsp_full_in = 1'b1;
                  end
                  // the last snapshot updates even when the event is dropped
                  last_axes_in = item_axes_ff;
                  last_ptr_in  = item_ptr_ff;
                  have_last_in = 1'b1;
               end
               rsp_count_in = ictr_pkg::STORED_W'(count_in);
               state_in     = ictr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ictr_pkg::ST_IDLE;
         end
      endcase

      // mode write: start a fresh run (the user must write it only while the block is idle; the block does not check)
      if (csr_wr_en) begin
         mode_in       = csr_wr_data;
         play_index_in = '0;
         case (csr_wr_data)
            ictr_pkg::MODE_RECORD: begin
               count_in     = '0;
               have_last_in = 1'b0;
               last_axes_in = '0;
               last_ptr_in  = '0;
            end
            ictr_pkg::MODE_PLAY: begin
               // keep the store; the first scan reloads event 0 when it is due
               held_axes_in = '0;
               held_ptr_in  = '0;
            end
            default: begin
               count_in     = '0;
               have_last_in = 1'b0;
               last_axes_in = '0;
               last_ptr_in  = '0;
               held_axes_in = '0;
               held_ptr_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ictr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ictr_pkg::MODE_IDLE;
         count_ff      <= '0;
         play_index_ff <= '0;
         have_last_ff  <= 1'b0;
         last_axes_ff  <= '0;
         last_ptr_ff   <= '0;
         held_axes_ff  <= '0;
         held_ptr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         play_index_ff <= play_index_in;
         have_last_ff  <= have_last_in;
         last_axes_ff  <= last_axes_in;
         last_ptr_ff   <= last_ptr_in;
         held_axes_ff  <= held_axes_in;
         held_ptr_ff   <= held_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      item_tick_ff  <= item_tick_in;
      item_axes_ff  <= item_axes_in;
      item_ptr_ff   <= item_ptr_in;
      rsp_axes_ff   <= rsp_axes_in;
      rsp_ptr_ff    <= rsp_ptr_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ------------------------------------------------------------------------
   // Response channel
   // ------------------------------------------------------------------------
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.applied_move_x    = signed'(rsp_axes_ff[0 +: ictr_pkg::AXIS_W]);
   assign rsp_ch.applied_move_y    = signed'(rsp_axes_ff[16 +: ictr_pkg::AXIS_W]);
   assign rsp_ch.applied_aim_x     = signed'(rsp_axes_ff[32 +: ictr_pkg::AXIS_W]);
   assign rsp_ch.applied_aim_y     = signed'(rsp_axes_ff[48 +: ictr_pkg::AXIS_W]);
   assign rsp_ch.applied_pointer_x = signed'(rsp_ptr_ff[0 +: ictr_pkg::AXIS_W]);
   assign rsp_ch.applied_pointer_y = signed'(rsp_ptr_ff[16 +: ictr_pkg::AXIS_W]);
   assign rsp_ch.applied_buttons   = rsp_ptr_ff[32 +: ictr_pkg::BTN_W];
   assign rsp_ch.event_stored      = rsp_stored_ff;
   assign rsp_ch.store_full        = rsp_full_ff;
   assign rsp_ch.stored_events     = rsp_count_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= ictr_pkg::CNT_W'(ictr_pkg::EVENT_DEPTH))
      else $error("event count beyond store depth");

   a_play_bound : assert property (@(posedge clock) disable iff (reset)
      play_index_ff <= count_ff)
      else $error("play index beyond event count");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_stored_ff && rsp_full_ff))
      else $error("event both stored and dropped");

   a_write_in_record : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (mode_ff == ictr_pkg::MODE_RECORD) && room)
      else $error("store write outside record or past depth");

   a_scan_monotonic : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ictr_pkg::ST_SCAN) |=> play_index_ff >= $past(play_index_ff))
      else $error("play index went backwards during scan");

endmodule

/* hdl/ictr_ram.sv */
// ----------------------------------------------------------------------------
// Event store RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ictr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* bench/input_change_trace_recorder_unit_test.sv */
// ----------------------------------------------------------------------------
// Input change trace recorder unit test
// Drives controller snapshots through the record, playback, idle and spare
// modes with random idling on both channels, and checks every applied
// snapshot and store status against a predictor of the recorder.
// ----------------------------------------------------------------------------
module input_change_trace_recorder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // quiet cycles allowed; the longest quiet stretch is the receiver hold-off
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_ITEMS  = 620;

   // one controller tick as offered on the request channel
   typedef struct {
      logic [ictr_pkg::TICK_W-1:0]        tick;
      logic signed [ictr_pkg::AXIS_W-1:0] move_x;
      logic signed [ictr_pkg::AXIS_W-1:0] move_y;
      logic signed [ictr_pkg::AXIS_W-1:0] aim_x;
      logic signed [ictr_pkg::AXIS_W-1:0] aim_y;
      logic signed [ictr_pkg::AXIS_W-1:0] pointer_x;
      logic signed [ictr_pkg::AXIS_W-1:0] pointer_y;
      logic [ictr_pkg::BTN_W-1:0]         buttons;
   } snapshot_type;

   // applied snapshot and store status as returned on the response channel
   typedef struct {
      logic signed [ictr_pkg::AXIS_W-1:0] move_x;
      logic signed [ictr_pkg::AXIS_W-1:0] move_y;
      logic signed [ictr_pkg::AXIS_W-1:0] aim_x;
      logic signed [ictr_pkg::AXIS_W-1:0] aim_y;
      logic signed [ictr_pkg::AXIS_W-1:0] pointer_x;
      logic signed [ictr_pkg::AXIS_W-1:0] pointer_y;
      logic [ictr_pkg::BTN_W-1:0]         buttons;
      logic                               event_stored;
      logic                               store_full;
      logic [ictr_pkg::STORED_W-1:0]      stored_events;
   } applied_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [1:0] csr_wr_data = ictr_pkg::MODE_IDLE;

   ictr_req_if req ();
   ictr_rsp_if rsp ();

   input_change_trace_recorder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: a private copy of the event store and run registers
   // ------------------------------------------------------------------------
   logic [ictr_pkg::TICK_W-1:0] trace_tick [ictr_pkg::EVENT_DEPTH];
   logic [ictr_pkg::AXES_W-1:0] trace_axes [ictr_pkg::EVENT_DEPTH];
   logic [ictr_pkg::PTR_W-1:0]  trace_ptr  [ictr_pkg::EVENT_DEPTH];
   int unsigned                 trace_count  = 0;
   int unsigned                 replay_pos   = 0;
   logic [ictr_pkg::AXES_W-1:0] seen_axes    = '0;
   logic [ictr_pkg::PTR_W-1:0]  seen_ptr     = '0;
   logic                        seen_valid   = 1'b0;
   logic [ictr_pkg::AXES_W-1:0] held_axes    = '0;
   logic [ictr_pkg::PTR_W-1:0]  held_ptr     = '0;
   logic [1:0]                  trace_mode   = ictr_pkg::MODE_IDLE;

   // applied snapshots still owed by the block, oldest first
   applied_type applied_queue [$];

   // run bookkeeping
   int failures        = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int mode_writes     = 0;
   int events_recorded = 0;
   int events_dropped  = 0;
   int deepest_replay  = 0;
   int holds_done      = 0;

   // idling control shared by sender and receiver
   bit no_idling    = 1'b0;
   bit hold_request = 1'b0;

   // span of ticks seen by the last recording session, used to aim playback
   logic [ictr_pkg::TICK_W-1:0] span_first = '0;
   logic [ictr_pkg::TICK_W-1:0] span_last  = '0;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // pack the four axes, pulling the most negative code up to the floor
   function automatic logic [ictr_pkg::AXES_W-1:0] pack_axes(input snapshot_type s);
      logic [ictr_pkg::AXIS_W-1:0] lane [4];
      lane[0] = s.move_x;
      lane[1] = s.move_y;
      lane[2] = s.aim_x;
      lane[3] = s.aim_y;
      foreach (lane[i])
         if (lane[i] == ictr_pkg::AXIS_MOST_NEG) lane[i] = ictr_pkg::AXIS_FLOOR;
      return {lane[3], lane[2], lane[1], lane[0]};
   endfunction

   function automatic void clear_run_state();
      trace_count = 0;
      replay_pos  = 0;
      seen_axes   = '0;
      seen_ptr    = '0;
      seen_valid  = 1'b0;
   endfunction

   // mirror a mode register write; every write starts a fresh run
   function automatic void apply_mode_write(input logic [1:0] m);
      trace_mode = m;
      case (m)
         ictr_pkg::MODE_RECORD: begin
            clear_run_state();
         end
         ictr_pkg::MODE_PLAY: begin
            // the store survives; an event at tick zero is held at once
            replay_pos = 0;
            held_axes  = '0;
            held_ptr   = '0;
            if (trace_count > 0 && trace_tick[0] == '0) begin
               held_axes = trace_axes[0];
               held_ptr  = trace_ptr[0];
            end
         end
         default: begin
            // idle and the spare code both clear everything
            clear_run_state();
            held_axes = '0;
            held_ptr  = '0;
         end
      endcase
   endfunction

   // work out the applied snapshot for one accepted tick and advance state
   function automatic applied_type predict_applied(input snapshot_type s);
      logic [ictr_pkg::AXES_W-1:0] axes;
      logic [ictr_pkg::AXES_W-1:0] out_axes;
      logic [ictr_pkg::PTR_W-1:0]  ptr;
      logic [ictr_pkg::PTR_W-1:0]  out_ptr;
      applied_type                 a;
      int                          consumed;
      axes     = pack_axes(s);
      ptr      = {s.buttons, s.pointer_y, s.pointer_x};
      out_axes = axes;
      out_ptr  = ptr;
      consumed = 0;
      a.event_stored = 1'b0;
      a.store_full   = 1'b0;
      case (trace_mode)
         ictr_pkg::MODE_RECORD: begin
            if (!seen_valid || axes != seen_axes || ptr != seen_ptr) begin
               if (trace_count < ictr_pkg::EVENT_DEPTH) begin
                  trace_tick[trace_count] = s.tick;
                  trace_axes[trace_count] = axes;
                  trace_ptr[trace_count]  = ptr;
                  trace_count++;
                  a.event_stored = 1'b1;
                  events_recorded++;
               end else begin
                  // no room: drop the event but still track the change
                  a.store_full = 1'b1;
                  events_dropped++;
               end
               seen_axes  = axes;
               seen_ptr   = ptr;
               seen_valid = 1'b1;
            end
         end
         ictr_pkg::MODE_PLAY: begin
            // consume every event due by this tick, unsigned compare
            while (replay_pos < trace_count && trace_tick[replay_pos] <= s.tick) begin
               held_axes = trace_axes[replay_pos];
               held_ptr  = trace_ptr[replay_pos];
               replay_pos++;
               consumed++;
            end
            if (consumed > deepest_replay) deepest_replay = consumed;
            out_axes = held_axes;
            out_ptr  = held_ptr;
         end
         default: ;
      endcase
      a.move_x        = out_axes[15:0];
      a.move_y        = out_axes[31:16];
      a.aim_x         = out_axes[47:32];
      a.aim_y         = out_axes[63:48];
      a.pointer_x     = out_ptr[15:0];
      a.pointer_y     = out_ptr[31:16];
      a.buttons       = out_ptr[43:32];
      a.stored_events = ictr_pkg::STORED_W'(trace_count);
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // often back to back, often a short gap, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idling) return 0;
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // favour the axis extremes so the clamp is hit often
   function automatic logic [ictr_pkg::AXIS_W-1:0] random_axis();
      case ($urandom_range(0, 15))
         0:       return ictr_pkg::AXIS_MOST_NEG;
         1:       return ictr_pkg::AXIS_FLOOR;
         2:       return 16'h7FFF;
         default: return ictr_pkg::AXIS_W'($urandom);
      endcase
   endfunction

   function automatic snapshot_type random_snapshot(input logic [ictr_pkg::TICK_W-1:0] t);
      snapshot_type s;
      s.tick      = t;
      s.move_x    = random_axis();
      s.move_y    = random_axis();
      s.aim_x     = random_axis();
      s.aim_y     = random_axis();
      s.pointer_x = ictr_pkg::AXIS_W'($urandom);
      s.pointer_y = ictr_pkg::AXIS_W'($urandom);
      s.buttons   = ictr_pkg::BTN_W'($urandom);
      return s;
   endfunction

   // change one thing, as a player would between ticks
   function automatic snapshot_type nudge_snapshot(input snapshot_type s);
      snapshot_type n;
      n = s;
      case ($urandom_range(0, 8))
         0: n.move_x    = random_axis();
         1: n.move_y    = random_axis();
         2: n.aim_x     = random_axis();
         3: n.aim_y     = random_axis();
         4: n.pointer_x = ictr_pkg::AXIS_W'($urandom);
         5: n.pointer_y = ictr_pkg::AXIS_W'($urandom);
         6: n.buttons   = s.buttons ^ (ictr_pkg::BTN_W'(1) <<
                                       $urandom_range(0, ictr_pkg::BTN_W - 1));
         7: n.buttons   = ictr_pkg::BTN_W'($urandom);
         default: begin
            // swap the two codes that clamp to the same value, or set the most negative one
            if (s.aim_y == ictr_pkg::AXIS_MOST_NEG)   n.aim_y = ictr_pkg::AXIS_FLOOR;
            else if (s.aim_y == ictr_pkg::AXIS_FLOOR) n.aim_y = ictr_pkg::AXIS_MOST_NEG;
            else                                      n.aim_y = ictr_pkg::AXIS_MOST_NEG;
         end
      endcase
      return n;
   endfunction

   // offer one snapshot at the falling edge, hold it until the transfer
   task automatic send_snapshot(input snapshot_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid     <= 1'b1;
      req.tick      <= s.tick;
      req.move_x    <= s.move_x;
      req.move_y    <= s.move_y;
      req.aim_x     <= s.aim_x;
      req.aim_y     <= s.aim_y;
      req.pointer_x <= s.pointer_x;
      req.pointer_y <= s.pointer_y;
      req.buttons   <= s.buttons;
      do @(posedge clock); while (req.ready !== 1'b1);
      applied_queue.push_back(predict_applied(s));
      items_sent++;
   endtask

   // drop valid, drain every owed result, settle, then write the mode
   task automatic write_mode(input logic [1:0] m);
      @(negedge clock);
      req.valid <= 1'b0;
      while (applied_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      apply_mode_write(m);
      mode_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // idle after reset and the spare code both pass the input straight through
   task automatic test_idle_passthrough();
      send_snapshot('{32'h0000_0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 12'h000});
      send_snapshot('{32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'h7FFF, 16'h7FFF, 12'hFFF});
      // most negative axes come back clamped, pointers do not
      send_snapshot('{32'h8000_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 16'h8000, 12'h800});
      send_snapshot('{32'h5555_5555, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                      16'hAAAA, 16'h5555, 12'hA55});
      write_mode(ictr_pkg::MODE_SPARE);
      send_snapshot(random_snapshot(32'd17));
      send_snapshot(random_snapshot(32'hFFFF_FFF0));
   endtask

   // first snapshot, repeats, clamp look-alikes and single-field changes
   task automatic test_record_basics();
      snapshot_type a;
      snapshot_type b;
      snapshot_type c;
      write_mode(ictr_pkg::MODE_RECORD);
      a = '{32'd0, 16'h8001, 16'h7FFF, 16'h0123, 16'hFEDC, 16'h8000, 16'h7FFF, 12'h001};
      send_snapshot(a);
      a.tick = 32'd1;
      send_snapshot(a);
      // -32768 clamps to the stored -32767, so this is no change
      a.tick   = 32'd2;
      a.move_x = ictr_pkg::AXIS_MOST_NEG;
      send_snapshot(a);
      b         = a;
      b.tick    = 32'd5;
      b.buttons = 12'h003;
      send_snapshot(b);
      b.tick = 32'd6;
      send_snapshot(b);
      c           = b;
      c.tick      = 32'd9;
      c.pointer_y = 16'h8000;
      c.buttons   = 12'hFFE;
      send_snapshot(c);
   endtask

   // replay the events at ticks 0, 5 and 9 recorded above
   task automatic test_playback_basics();
      write_mode(ictr_pkg::MODE_PLAY);
      send_snapshot(random_snapshot(32'd3));
      send_snapshot(random_snapshot(32'd5));
      // a tick that goes back consumes nothing further
      send_snapshot(random_snapshot(32'd2));
      send_snapshot(random_snapshot(32'hFFFF_FFFF));
      // restart and consume all three events in one tick
      write_mode(ictr_pkg::MODE_PLAY);
      send_snapshot(random_snapshot(32'd9));
      // an empty store replays zeros
      write_mode(ictr_pkg::MODE_IDLE);
      write_mode(ictr_pkg::MODE_PLAY);
      send_snapshot(random_snapshot(32'd7));
   endtask

   // hold the receiver off while items keep coming so the block stalls
   task automatic test_backpressure();
      snapshot_type s;
      write_mode(ictr_pkg::MODE_RECORD);
      no_idling    = 1'b1;
      hold_request = 1'b1;
      s = random_snapshot(32'd100);
      for (int i = 0; i < 8; i++) begin
         s      = nudge_snapshot(s);
         s.tick = s.tick + 1;
         send_snapshot(s);
      end
      no_idling = 1'b0;
   endtask

   task automatic record_session();
      snapshot_type cur;
      logic [31:0]  t;
      int           n;
      write_mode(ictr_pkg::MODE_RECORD);
      n   = $urandom_range(8, 25);
      t   = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      cur = random_snapshot(t);
      span_first = t;
      for (int i = 0; i < n; i++) begin
         if (i > 0) begin
            t = t + $urandom_range(0, 3);
            if ($urandom_range(0, 99) < 5)       cur = random_snapshot(t);
            else if ($urandom_range(0, 99) < 40) cur = nudge_snapshot(cur);
         end
         cur.tick = t;
         send_snapshot(cur);
      end
      span_last = t;
   endtask

   // sweep the recorded span, with the odd step back or jump to the top
   task automatic playback_session();
      logic [31:0] t;
      int          n;
      int unsigned step;
      int          r;
      write_mode(ictr_pkg::MODE_PLAY);
      n    = $urandom_range(6, 20);
      step = (span_last - span_first) / n + 1;
      t    = span_first - $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8)       t = t - $urandom_range(1, 4);
         else if (r < 12) t = 32'hFFFF_FFFF;
         else if (i > 0)  t = t + $urandom_range(0, 2 * step);
         send_snapshot(random_snapshot(t));
      end
   endtask

   task automatic test_random_sessions();
      int start;
      int kind;
      int n;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         // now and then a whole session without any idling
         no_idling = ($urandom_range(0, 5) == 0);
         kind      = $urandom_range(0, 99);
         if (kind < 60) begin
            record_session();
            playback_session();
         end else if (kind < 80) begin
            playback_session();
         end else begin
            write_mode(kind < 90 ? ictr_pkg::MODE_IDLE : ictr_pkg::MODE_SPARE);
            n = $urandom_range(3, 10);
            for (int i = 0; i < n; i++) send_snapshot(random_snapshot($urandom));
         end
      end
      no_idling = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            if (stall_left == 0 && $urandom_range(0, 99) < 25) stall_left = pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               rsp.ready <= 1'b0;
            end else begin
               rsp.ready <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checking at the rising edge
   // ------------------------------------------------------------------------
   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      applied_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (applied_queue.size() == 0) begin
            $error("response transfer with no applied snapshot owed");
            failures++;
         end else begin
            want = applied_queue.pop_front();
            check_field("applied_move_x",    want.move_x,        rsp.applied_move_x);
            check_field("applied_move_y",    want.move_y,        rsp.applied_move_y);
            check_field("applied_aim_x",     want.aim_x,         rsp.applied_aim_x);
            check_field("applied_aim_y",     want.aim_y,         rsp.applied_aim_y);
            check_field("applied_pointer_x", want.pointer_x,     rsp.applied_pointer_x);
            check_field("applied_pointer_y", want.pointer_y,     rsp.applied_pointer_y);
            check_field("applied_buttons",   want.buttons,       rsp.applied_buttons);
            check_field("event_stored",      want.event_stored,  rsp.event_stored);
            check_field("store_full",        want.store_full,    rsp.store_full);
            check_field("stored_events",     want.stored_events, rsp.stored_events);
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run after too long without any transfer or write
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1) || csr_wr_en) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("** input_change_trace_recorder_unit: FAILED **");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   initial begin
      // initialise every block input before reset releases
      req.valid     = 1'b0;
      req.tick      = '0;
      req.move_x    = '0;
      req.move_y    = '0;
      req.aim_x     = '0;
      req.aim_y     = '0;
      req.pointer_x = '0;
      req.pointer_y = '0;
      req.buttons   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_passthrough();
      test_record_basics();
      test_playback_basics();
      test_backpressure();
      test_random_sessions();

      // drop valid, drain, then give stray results time to show up
      @(negedge clock);
      req.valid <= 1'b0;
      while (applied_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d snapshots over %0d mode writes and %0d long hold-offs.",
               items_sent, mode_writes, holds_done);
      $display("Checked %0d results, recorded %0d events, dropped %0d, longest replay %0d.",
               results_checked, events_recorded, events_dropped, deepest_replay);
      if (failures == 0) begin
         $display("** input_change_trace_recorder_unit: PASSED **");
      end else begin
         $display("** input_change_trace_recorder_unit: FAILED **");
      end
      $finish;
   end

endmodule
